### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL. Build with NO_ASSERTIONS
// defined to strip them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define ASSERT_RULE(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// cond must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_RULE(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### hw/rtl/ecrp_pkg.sv
// ----------------------------------------------------------------------------
// ecrp_pkg
// Shared widths, register indexes and divider interface types for the
// equal-count row partitioner.
// ----------------------------------------------------------------------------
package ecrp_pkg;

  localparam int unsigned POINT_W   = 16;  // point counts
  localparam int unsigned ROWS_W    = 9;   // row count, up to 256
  localparam int unsigned ROW_W     = 8;   // row index
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OUT_W     = ROW_W + POINT_W;
  localparam int unsigned DIV_CNT_W = $clog2(POINT_W);

  localparam logic [ROWS_W-1:0] MIN_ROWS = ROWS_W'(2);
  localparam logic [ROWS_W-1:0] MAX_ROWS = ROWS_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_TOTAL = 1'b0,
    CFG_ROW_COUNT   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic [POINT_W-1:0] dividend;
    logic [ROWS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               valid;
    logic [POINT_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/equal_count_row_partitioner_core.sv
// ----------------------------------------------------------------------------
// equal_count_row_partitioner_core
// Assigns each run of equal-y points to a row so all rows hold about the
// same number of points.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one run size per transfer. m_axis returns one transfer per
//   run: the assigned row and the echoed run size in tdata, tlast high when
//   the run consumes the last point of the set (partition state then
//   restarts for the next set).
//   cfg writes the point total (index 0) and row_count (index 1); it is
//   always ready and should only be written between runs.
// Sequence:
//   The decision is made after the input transfer, once the output register is
//   free, and the result is registered then. A run that does not end the set
//   then recomputes the target row size with the 16-step divider; the next run
//   is taken only after the new quotient has come back. A run that ends the
//   set skips the division and returns to idle for the next run.
// Reset:
//   Partition state clears, point total = 1, row_count = 2.
// Stall:
//   A result waits in the output register while the divider runs; a new
//   decision waits until that register has been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module equal_count_row_partitioner_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [15:0] run_size
  input  logic [ecrp_pkg::POINT_W-1:0]          s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [7:0] row_index, [23:8] run_points
  output logic [ecrp_pkg::OUT_W-1:0]            m_axis_tdata_o,
  output logic                                  m_axis_tlast_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ecrp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ecrp_pkg::POINT_W-1:0]          cfg_data_i
);
  import ecrp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECIDE = 3'b010,
    ST_DIVIDE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [POINT_W-1:0] total_q, total_d;
  logic [ROWS_W-1:0]  rows_q, rows_d;
  logic [POINT_W-1:0] consumed_q, consumed_d;
  logic [POINT_W-1:0] fill_q, fill_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [POINT_W-1:0] target_q, target_d;
  logic [POINT_W-1:0] run_q, run_d;
  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_data_q, out_data_d;
  logic               out_last_q, out_last_d;

  logic [POINT_W-1:0] eff_total;
  logic [ROWS_W-1:0]  eff_rows;
  logic [ROWS_W-1:0]  rows_m1;
  logic [ROW_W-1:0]   row_c;
  logic               last_row;
  logic [POINT_W:0]   sum_new;
  logic [POINT_W:0]   dist_new;
  logic [POINT_W-1:0] dist_old;
  logic               advance;
  logic [ROW_W-1:0]   row_new;
  logic [POINT_W:0]   consumed_sum;
  logic               set_done;
  logic [POINT_W-1:0] fill_new;
  logic [POINT_W-1:0] div_num;
  logic [ROWS_W-1:0]  div_den;
  logic               in_xfer;
  logic               out_free;
  logic               decide_go;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ecrp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Effective register values and the per-run decision
  always_comb begin
    eff_total = (total_q == '0) ? POINT_W'(1) : total_q;
    if (rows_q < MIN_ROWS) begin
      eff_rows = MIN_ROWS;
    end else if (rows_q > MAX_ROWS) begin
      eff_rows = MAX_ROWS;
    end else begin
      eff_rows = rows_q;
    end
    rows_m1  = eff_rows - 1'b1;
    // row count may have been lowered mid-set
    row_c    = ({1'b0, row_q} > rows_m1) ? rows_m1[ROW_W-1:0] : row_q;
    last_row = ({1'b0, row_c} == rows_m1);

    sum_new  = {1'b0, fill_q} + {1'b0, run_q};
    dist_new = (sum_new >= {1'b0, target_q}) ? (sum_new - {1'b0, target_q})
                                             : ({1'b0, target_q} - sum_new);
    dist_old = (fill_q >= target_q) ? (fill_q - target_q) : (target_q - fill_q);
    advance  = (fill_q != '0) && (dist_new > {1'b0, dist_old}) && !last_row;
    row_new  = row_c + ROW_W'(advance);

    consumed_sum = {1'b0, consumed_q} + {1'b0, run_q};
    set_done     = (consumed_sum >= {1'b0, eff_total});
    fill_new     = advance ? run_q : sum_new[POINT_W-1:0];
    // remaining + new fill; the run size cancels out of both branches
    div_num      = eff_total - consumed_q + (advance ? '0 : fill_q);
    div_den      = eff_rows - {1'b0, row_new};
  end

  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign decide_go = (state_q == ST_DECIDE) && out_free;

  always_comb begin
    state_d     = state_q;
    consumed_d  = consumed_q;
    fill_d      = fill_q;
    row_d       = row_q;
    target_d    = target_q;
    run_d       = run_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    div_req     = '{start: 1'b0, dividend: div_num, divisor: div_den};

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          run_d   = s_axis_tdata_i;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (decide_go) begin
          out_valid_d = 1'b1;
          out_data_d  = {run_q, row_new};
          out_last_d  = set_done;
          if (set_done) begin
            consumed_d = '0;
            fill_d     = '0;
            row_d      = '0;
            state_d    = ST_IDLE;
          end else begin
            consumed_d    = consumed_sum[POINT_W-1:0];
            fill_d        = fill_new;
            row_d         = row_new;
            div_req.start = 1'b1;
            state_d       = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.valid) begin
          target_d = div_rsp.quotient;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration writes
  always_comb begin
    total_d = total_q;
    rows_d  = rows_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POINT_TOTAL: total_d = cfg_data_i;
        CFG_ROW_COUNT:   rows_d  = cfg_data_i[ROWS_W-1:0];
        default:         total_d = total_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= POINT_W'(1);
      rows_q      <= MIN_ROWS;
      consumed_q  <= '0;
      fill_q      <= '0;
      row_q       <= '0;
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      rows_q      <= rows_d;
      consumed_q  <= consumed_d;
      fill_q      <= fill_d;
      row_q       <= row_d;
      target_q    <= target_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign cfg_ready_o     = 1'b1;

  `ASSERT_RULE(a_busy_after_accept, clk_i, rst_ni, in_xfer |=> !s_axis_tready_o)
  `ASSERT_RULE(a_ready_div_idle, clk_i, rst_ni, s_axis_tready_o |-> !div_rsp.busy)
  `ASSERT_RULE(a_div_rsp_expected, clk_i, rst_ni, div_rsp.valid |-> (state_q == ST_DIVIDE))
  `ASSERT_NEVER(a_fill_le_consumed, clk_i, rst_ni, fill_q > consumed_q)

endmodule

### hw/rtl/ecrp_div.sv
// ----------------------------------------------------------------------------
// ecrp_div
// Radix-2 restoring divider: 16-bit dividend by 9-bit divisor, one quotient
// bit per cycle. valid pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module ecrp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ecrp_pkg::div_req_t req_i,
  output ecrp_pkg::div_rsp_t rsp_o
);
  import ecrp_pkg::*;

  logic                 busy_q, busy_d;
  logic                 valid_q, valid_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [POINT_W-1:0]   quo_q, quo_d;
  logic [ROWS_W-1:0]    rem_q, rem_d;
  logic [ROWS_W-1:0]    dvs_q, dvs_d;
  logic [ROWS_W:0]      trial;

  always_comb begin
    trial   = {rem_q, quo_q[POINT_W-1]};
    busy_d  = busy_q;
    valid_d = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    priority if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(POINT_W - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // quotient register doubles as the dividend shifter
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = ROWS_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[POINT_W-2:0], 1'b1};
      end else begin
        rem_d = trial[ROWS_W-1:0];
        quo_d = {quo_q[POINT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d  = 1'b0;
        valid_d = 1'b1;
      end
    end else begin
      // idle: hold
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o = '{busy: busy_q, valid: valid_q, quotient: quo_q};

endmodule

### dv/equal_count_row_partitioner_core_test.sv
// ----------------------------------------------------------------------------
// equal_count_row_partitioner_core_test
// Self-checking bench for the equal-count row partitioner. Run sizes go in on
// s_axis while a local model of the partition state predicts row, echoed size
// and set end for every transfer; m_axis results are checked in order.
// Directed cases cover reset values, register clamping, ties, row count
// lowered mid-set and overrun, followed by back-pressure and random sets.
// ----------------------------------------------------------------------------
module equal_count_row_partitioner_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ecrp_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 24;      // divider pass after the last result
  localparam int unsigned CYCLE_LIMIT  = 400_000;

  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic [POINT_W-1:0] run_points;
    logic               set_done;
  } row_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic [POINT_W-1:0]   s_data = '0;
  logic                 m_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  cfg_idx_e             cfg_index = CFG_POINT_TOTAL;
  logic [POINT_W-1:0]   cfg_data = '0;

  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [OUT_W-1:0]     m_axis_tdata_o;
  logic                 m_axis_tlast_o;
  logic                 cfg_ready_o;

  // partition model state and register copies
  logic [POINT_W-1:0]   reg_total;
  logic [ROWS_W-1:0]    reg_rows;
  logic [POINT_W-1:0]   pts_used;
  logic [POINT_W-1:0]   fill;
  logic [ROW_W-1:0]     cur_row;
  logic [POINT_W-1:0]   target;

  row_result_t          expected_rows[$];
  int unsigned          fails = 0;
  int unsigned          cycle_count = 0;
  bit                   unbroken = 1'b0;
  int unsigned          hold_reqs = 0;
  int unsigned          holds_served = 0;
  int unsigned          hold_left = 0;

  equal_count_row_partitioner_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  function automatic int unsigned eff_total();
    return (reg_total == '0) ? 1 : int'(reg_total);
  endfunction

  function automatic int unsigned eff_rows();
    if (reg_rows < MIN_ROWS) return MIN_ROWS;
    if (reg_rows > MAX_ROWS) return MAX_ROWS;
    return reg_rows;
  endfunction

  function automatic int unsigned abs_diff(input int unsigned a, input int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic void clear_partition();
    pts_used = '0;
    fill     = '0;
    cur_row  = '0;
    target   = POINT_W'(eff_total() / eff_rows());
  endfunction

  function automatic row_result_t assign_row(input logic [POINT_W-1:0] size);
    int unsigned total, rows, row, s, consumed;
    row_result_t res;
    total = eff_total();
    rows  = eff_rows();
    row   = cur_row;
    s     = size;
    if (row > rows - 1) row = rows - 1;
    if (pts_used == '0) target = POINT_W'(total / rows);
    // advance only if joining moves the row farther from target; last row absorbs
    if (fill != '0 && abs_diff(fill + s, target) > abs_diff(fill, target) &&
        row < rows - 1) begin
      row++;
      fill = '0;
    end
    consumed       = pts_used + s;
    res.row_index  = ROW_W'(row);
    res.run_points = size;
    res.set_done   = (consumed >= total);
    if (res.set_done) begin
      clear_partition();
    end else begin
      pts_used = POINT_W'(consumed);
      fill     = POINT_W'(fill + s);
      cur_row  = ROW_W'(row);
      target   = POINT_W'((total - consumed + fill) / (rows - row));
    end
    return res;
  endfunction

  // ------------------------------------------------------------ checking
  always @(posedge clk_i) begin : result_monitor
    row_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected result transfer: tdata=%h tlast=%b",
               m_axis_tdata_o, m_axis_tlast_o);
        fails++;
      end else begin
        want = expected_rows.pop_front();
        if (m_axis_tdata_o[ROW_W-1:0] !== want.row_index) begin
          $error("row_index: expected %0d, got %0d", want.row_index,
                 m_axis_tdata_o[ROW_W-1:0]);
          fails++;
        end
        if (m_axis_tdata_o[OUT_W-1:ROW_W] !== want.run_points) begin
          $error("run_points: expected %0d, got %0d", want.run_points,
                 m_axis_tdata_o[OUT_W-1:ROW_W]);
          fails++;
        end
        if (m_axis_tlast_o !== want.set_done) begin
          $error("set_done: expected %0b, got %0b", want.set_done, m_axis_tlast_o);
          fails++;
        end
      end
    end
  end

  // receiver ready, with long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_reqs != holds_served) begin
      holds_served <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
      m_ready      <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= unbroken || ($urandom_range(99) >= 24);
    end
  end

  // ------------------------------------------------------------- drivers
  task automatic send_run(input logic [POINT_W-1:0] size);
    if (!unbroken) begin
      while ($urandom_range(99) < 24) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= size;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_rows.insert(expected_rows.size(), assign_row(size));
  endtask

  // register writes belong between runs: callers drain first
  task automatic configure(input bit set_total, input logic [POINT_W-1:0] total_word,
                           input bit set_rows, input logic [POINT_W-1:0] rows_word);
    if (set_total) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_POINT_TOTAL;
      cfg_data  <= total_word;
      do @(posedge clk_i); while (!cfg_ready_o);
      reg_total = total_word;
    end
    if (set_rows) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_ROW_COUNT;
      cfg_data  <= rows_word;
      do @(posedge clk_i); while (!cfg_ready_o);
      reg_rows = rows_word[ROWS_W-1:0];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ------------------------------------------------------ random values
  function automatic logic [POINT_W-1:0] random_total_word();
    case ($urandom_range(9))
      0:       return POINT_W'($urandom_range(3, 0));
      1:       return POINT_W'($urandom_range(65535, 60000));
      2:       return '1;
      default: return POINT_W'($urandom_range(3000, 4));
    endcase
  endfunction

  // upper bits beyond the row count field are random and ignored
  function automatic logic [POINT_W-1:0] random_rows_word();
    logic [ROWS_W-1:0] r;
    case ($urandom_range(9))
      0:       r = ROWS_W'($urandom_range(1, 0));
      1:       r = ROWS_W'($urandom_range(511, 257));
      2:       r = MAX_ROWS;
      3:       r = ROWS_W'($urandom_range(255, 25));
      default: r = ROWS_W'($urandom_range(24, 2));
    endcase
    return {(POINT_W-ROWS_W)'($urandom), r};
  endfunction

  function automatic logic [POINT_W-1:0] random_run_size();
    int unsigned hi;
    hi = 2 * (eff_total() / eff_rows()) + 1;
    if (hi > 65535) hi = 65535;
    case ($urandom_range(19))
      0:       return '0;
      1:       return POINT_W'($urandom);
      default: return POINT_W'($urandom_range(hi, 1));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_defaults();
    // total 1, two rows: single point ends the set, empty run does not
    send_run(16'd1);
    send_run(16'd0);
    send_run(16'hFFFF);
    wait_drained();
  endtask

  task automatic test_register_limits();
    configure(1'b1, 16'h0000, 1'b1, 16'h0000);   // clamp to 1 point, 2 rows
    send_run(16'd2);
    wait_drained();
    configure(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);   // all ones: rows clamp to max
    send_run(16'hFFFF);
    wait_drained();
    configure(1'b0, '0, 1'b1, 16'h0001);
    send_run(16'h8000);
    send_run(16'h7FFF);
    wait_drained();
  endtask

  task automatic test_tie_and_advance();
    configure(1'b1, 16'd30, 1'b1, 16'd2);
    // second run lands exactly as far from target as before: joins
    send_run(16'd10);
    send_run(16'd10);
    send_run(16'd1);
    send_run(16'd9);
    wait_drained();
  endtask

  task automatic test_row_count_lowered();
    configure(1'b1, 16'd80, 1'b1, 16'd8);
    send_run(16'd10);
    send_run(16'd10);
    send_run(16'd10);
    wait_drained();
    // current row now past the last row: clamps and cannot advance
    configure(1'b0, '0, 1'b1, 16'd2);
    send_run(16'd30);
    send_run(16'd20);
    wait_drained();
  endtask

  task automatic test_overrun();
    configure(1'b1, 16'd10, 1'b1, 16'd2);
    send_run(16'd7);
    send_run(16'd7);
    wait_drained();
    configure(1'b1, 16'd50, 1'b1, 16'd4);
    send_run(16'd20);
    wait_drained();
    configure(1'b1, 16'd10, 1'b0, '0);            // total drops below consumed
    send_run(16'd0);
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    configure(1'b1, 16'd200, 1'b1, 16'd5);
    hold_reqs <= hold_reqs + 1;
    repeat (10) send_run(random_run_size());
    wait_drained();
  endtask

  task automatic run_random_sets(input int unsigned item_goal);
    int unsigned sent;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(1) == 1) begin
        wait_drained();
        configure(1'b1, random_total_word(), 1'b1, random_rows_word());
      end
      do begin
        if ($urandom_range(149) == 0) begin
          wait_drained();
          if ($urandom_range(1) == 1) configure(1'b0, '0, 1'b1, random_rows_word());
          else configure(1'b1, random_total_word(), 1'b0, '0);
        end
        send_run(random_run_size());
        sent++;
      end while (pts_used != '0 && sent < item_goal);
    end
    wait_drained();
  endtask

  task automatic test_random_sets();
    run_random_sets(650);
  endtask

  task automatic test_unbroken_flow();
    unbroken = 1'b1;
    run_random_sets(150);
    unbroken = 1'b0;
  endtask

  initial begin
    reg_total = POINT_W'(1);
    reg_rows  = MIN_ROWS;
    clear_partition();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_limits();
    test_tie_and_advance();
    test_row_count_lowered();
    test_overrun();
    test_output_hold_off();
    test_random_sets();
    test_unbroken_flow();

    wait_drained();
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ecrp_pkg.sv
hw/rtl/ecrp_div.sv
hw/rtl/equal_count_row_partitioner_core.sv
dv/equal_count_row_partitioner_core_test.sv
